@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/swld_pkg.sv @@
package swld_pkg;

    localparam int NUM_DIGITS = 6;

    localparam logic [3:0] BTN_START = 4'b0001;
    localparam logic [3:0] BTN_STOP  = 4'b0010;
    localparam logic [3:0] BTN_LAP   = 4'b0100;
    localparam logic [3:0] BTN_CLEAR = 4'b1000;

    localparam logic [9:0]  SW_LAP_SEL   = 10'd1;
    localparam logic [31:0] PERIOD_RESET = 32'hF4240;

    // digit moduli, least significant first: hh ones, hh tens, ss ones, ss tens, mm ones, mm tens
    localparam int DIGIT_MODULUS [NUM_DIGITS] = '{10, 10, 10, 6, 10, 6};

    typedef struct packed {
        logic [3:0] buttons;
        logic [9:0] switches;
    } cmd_t;

    typedef struct packed {
        logic [31:0] seg_low;
        logic [15:0] seg_high;
        logic        running;
    } disp_t;

    typedef struct packed {
        logic inc;
        logic clear;
        logic lap;
        logic show_count;
        logic show_lap;
    } ctrl_t;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7C;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h67;
            default: code = 8'h3F;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/swld_digit_cell.sv @@
module swld_digit_cell #(
    parameter int DIGIT_MOD = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  swld_pkg::ctrl_t ctrl,
    input  logic           carry_in,
    output logic           carry_out,
    output logic [7:0]     seg_next
);

    localparam logic [3:0] DIGIT_MAX = 4'(DIGIT_MOD - 1);

    logic [3:0] count_reg, count_next;
    logic [3:0] lap_reg, lap_next;
    logic [3:0] shown_reg, shown_next;

    assign carry_out = carry_in && (count_reg == DIGIT_MAX);

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (carry_in)
        begin
            count_next = (count_reg == DIGIT_MAX) ? 4'd0 : count_reg + 4'd1;
        end
    end

    always_comb
    begin
        shown_next = shown_reg;
        priority if (ctrl.clear)
        begin
            shown_next = '0;
        end
        else if (ctrl.show_count)
        begin
            shown_next = count_next;
        end
        else if (ctrl.show_lap)
        begin
            shown_next = lap_reg;
        end
    end

    assign lap_next = ctrl.lap ? count_reg : lap_reg;
    assign seg_next = swld_pkg::seg_of(shown_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            lap_reg   <= '0;
            shown_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            lap_reg   <= lap_next;
            shown_reg <= shown_next;
        end
    end

endmodule

@@ rtl/swld_ctrl.sv @@
`include "assert_macros.svh"

module swld_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  swld_pkg::cmd_t  cmd,
    input  logic            cfg_write,
    input  logic [31:0]     cfg_data,
    output swld_pkg::ctrl_t ctrl,
    output logic            run_next
);

    logic        run_reg;
    logic [31:0] period_reg;
    logic [31:0] presc_reg, presc_next;
    logic [32:0] presc_inc;
    logic        tick;

    assign presc_inc = {1'b0, presc_reg} + 33'd1;
    assign tick      = presc_inc >= {1'b0, period_reg};

    always_comb
    begin
        run_next   = run_reg;
        presc_next = presc_reg;
        ctrl       = '0;
        if (accept)
        begin
            if (!run_reg)
            begin
                priority if (cmd.buttons == swld_pkg::BTN_START)
                begin
                    run_next = 1'b1;
                end
                else if (cmd.buttons == swld_pkg::BTN_CLEAR)
                begin
                    ctrl.clear = 1'b1;
                    presc_next = '0;
                end
                else if (cmd.buttons == swld_pkg::BTN_LAP)
                begin
                    ctrl.lap = 1'b1;
                end
                else if (cmd.switches == swld_pkg::SW_LAP_SEL)
                begin
                    ctrl.show_lap = 1'b1;
                end
            end
            else
            begin
                priority if (cmd.buttons == swld_pkg::BTN_STOP)
                begin
                    run_next = 1'b0;
                end
                else if (tick)
                begin
                    presc_next      = '0;
                    ctrl.inc        = 1'b1;
                    ctrl.show_count = 1'b1;
                end
                else if (cmd.buttons == swld_pkg::BTN_CLEAR)
                begin
                    ctrl.clear = 1'b1;
                    presc_next = '0;
                    run_next   = 1'b0;
                end
                else if (cmd.buttons == swld_pkg::BTN_LAP)
                begin
                    ctrl.lap   = 1'b1;
                    presc_next = presc_inc[31:0];
                end
                else if (cmd.switches == swld_pkg::SW_LAP_SEL)
                begin
                    ctrl.show_lap = 1'b1;
                    presc_next    = presc_inc[31:0];
                end
                else
                begin
                    presc_next = presc_inc[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg    <= 1'b0;
            presc_reg  <= '0;
            period_reg <= swld_pkg::PERIOD_RESET;
        end
        else
        begin
            run_reg   <= run_next;
            presc_reg <= presc_next;
            if (cfg_write)
            begin
                period_reg <= cfg_data;
            end
        end
    end

    `ASSERT_NEXT(a_tick_restarts_prescaler, clk, rst_n, ctrl.inc, presc_reg == 32'd0)
    `ASSERT_NEXT(a_clear_stops, clk, rst_n, ctrl.clear, !run_reg && presc_reg == 32'd0)
    `ASSERT_NEXT(a_stop_holds_prescaler, clk, rst_n,
        accept && run_reg && cmd.buttons == swld_pkg::BTN_STOP,
        !run_reg && $stable(presc_reg))

endmodule

@@ rtl/stopwatch_with_lap_display.sv @@
// Stopwatch with lap register and six-digit seven-segment display (mm ss hh).
// cmd channel (cmd_valid/cmd_stall/cmd_data): one transaction per clock sample
//   of the button and switch words; while running, one that is no stop or clear advances the prescaler.
// disp channel (disp_valid/disp_stall/disp_data): one transaction per cmd
//   transaction, carrying the segment bytes of the shown value and the run flag.
// cfg channel (cfg_valid/cfg_ready/cfg_data): writes the prescaler period in
//   cmd transactions per hundredth; cfg_ready is always high.
// disp_valid is registered and rises in the cycle after a cmd transaction; throughput is one
//   transaction per cycle while disp_stall does not hold the output; the carry ripple through the
//   row of six digit cells and the prescaler compare are combinational.
// The display holds one result in an output register; while disp_stall holds
//   it back, cmd_stall is raised and no new sample is taken.
// Reset stops the watch, clears count, lap and shown digits to zero, restarts the
//   prescaler and loads a period of 1000000 cmd transactions.
module stopwatch_with_lap_display (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  swld_pkg::cmd_t   cmd_data,
    output logic             disp_valid,
    input  logic             disp_stall,
    output swld_pkg::disp_t  disp_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [31:0]      cfg_data
);

    logic                                  accept;
    logic                                  run_next;
    swld_pkg::ctrl_t                       ctrl;
    logic [swld_pkg::NUM_DIGITS:0]         carry;
    logic [swld_pkg::NUM_DIGITS-1:0][7:0]  seg;
    logic                                  disp_valid_reg;
    swld_pkg::disp_t                       disp_data_reg;

    assign cfg_ready = 1'b1;
    assign cmd_stall = disp_valid_reg && disp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    swld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd_data),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .ctrl      (ctrl),
        .run_next  (run_next)
    );

    assign carry[0] = ctrl.inc;

    for (genvar i = 0; i < swld_pkg::NUM_DIGITS; i++)
    begin : g_digit
        swld_digit_cell #(
            .DIGIT_MOD (swld_pkg::DIGIT_MODULUS[i])
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .seg_next  (seg[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            disp_valid_reg <= 1'b1;
        end
        else if (!disp_stall)
        begin
            disp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            disp_data_reg.seg_low  <= {seg[3], seg[2], seg[1], seg[0]};
            disp_data_reg.seg_high <= {seg[5], seg[4]};
            disp_data_reg.running  <= run_next;
        end
    end

    assign disp_valid = disp_valid_reg;
    assign disp_data  = disp_data_reg;

endmodule
